@@ design/dcbv_pkg.sv @@
// shared types, codes and constants of the daisy-chain burst vibration controller
`default_nettype none

package dcbv_pkg;

	// input item: serial word or modulation tick
	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
		logic       rx_parity;
	} req_t;

	// result item
	typedef struct packed {
		logic       fwd_valid;
		logic [7:0] fwd_byte;
		logic       fwd_parity;
		logic       drive_on;
		logic [7:0] period_value;
		logic [7:0] compare_high;
		logic [6:0] compare_low;
		logic       outputs_opposite;
		logic [6:0] duty_level;
	} rsp_t;

	// classified operation codes
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_TICK  = 3'd1;
	localparam logic [2:0] OP_FWD   = 3'd2;
	localparam logic [2:0] OP_START = 3'd3;
	localparam logic [2:0] OP_STOP  = 3'd4;
	localparam logic [2:0] OP_DATA  = 3'd5;

	// operation handed from front to back
	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       parity;
	} op_t;

	// capture protocol phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_DUTY = 2'd1;
	localparam logic [1:0] PH_FREQ = 2'd2;

	localparam logic [7:0] PHASE_LAST   = 8'd199;
	localparam logic [7:0] HALF_PHASES  = 8'd100;
	localparam logic [6:0] DUTY_MAX     = 7'd99;
	localparam logic [6:0] LOW_COMPARE  = 7'd64;
	localparam logic [2:0] FREQ_RESET   = 3'd3;

	// pwm period per frequency select
	function automatic logic [7:0] period_lookup(input logic [2:0] sel);
		logic [7:0] p;
		case (sel)
			3'd0:    p = 8'd85;
			3'd1:    p = 8'd72;
			3'd2:    p = 8'd60;
			3'd3:    p = 8'd52;
			3'd4:    p = 8'd44;
			3'd5:    p = 8'd37;
			3'd6:    p = 8'd32;
			3'd7:    p = 8'd27;
			default: p = 8'd85;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

@@ design/dcbv_front.sv @@
// front end: parity check and decode of received words into operations
`default_nettype none

module dcbv_front (
	input  wire  dcbv_pkg::req_t req,
	output dcbv_pkg::op_t        op
);

	logic       par_ok;
	logic [5:0] addr;
	logic [7:0] fwd_b;

	assign par_ok = ((^req.rx_byte) == req.rx_parity);
	assign addr   = req.rx_byte[6:1];
	assign fwd_b  = {1'b0, addr - 6'd1, req.rx_byte[0]};

	// classify the item
	always_comb begin
		op.kind   = dcbv_pkg::OP_NONE;
		op.data   = req.rx_byte;
		op.parity = req.rx_parity;
		if (req.cmd) begin
			op.kind = dcbv_pkg::OP_TICK;
		end else if (!par_ok) begin
			op.kind = dcbv_pkg::OP_NONE;
		end else if (req.rx_byte[7]) begin
			op.kind = dcbv_pkg::OP_DATA;
		end else if (addr != 6'd0) begin
			op.kind   = dcbv_pkg::OP_FWD;
			op.data   = fwd_b;
			op.parity = ^fwd_b;
		end else if (req.rx_byte[0]) begin
			op.kind = dcbv_pkg::OP_START;
		end else begin
			op.kind = dcbv_pkg::OP_STOP;
		end
	end

endmodule

`default_nettype wire

@@ design/dcbv_queue.sv @@
// small register queue of operations between front and back
`default_nettype none

module dcbv_queue #(
	parameter int DEPTH = 2
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire  dcbv_pkg::op_t push_op,
	output logic                full,
	input  wire                 pop,
	output logic                not_empty,
	output dcbv_pkg::op_t       head_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	dcbv_pkg::op_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign head_op   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ design/dcbv_back.sv @@
// back end: protocol state, modulation counter and result register
`default_nettype none

module dcbv_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  op_valid,
	input  wire  dcbv_pkg::op_t  op,
	output logic                 op_pop,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	output dcbv_pkg::rsp_t       rsp
);

	logic [1:0] proto_q;
	logic [6:0] pending_q;
	logic [2:0] freq_q;
	logic [6:0] level_q;
	logic [6:0] burst_duty_q;
	logic       drive_q;
	logic [7:0] phase_q;
	logic       opposite_q;
	logic       full_q;
	logic [7:0] held_q;

	logic [1:0] proto_d;
	logic [6:0] pending_d;
	logic [2:0] freq_d;
	logic [6:0] level_d;
	logic [6:0] burst_duty_d;
	logic       drive_d;
	logic [7:0] phase_d;
	logic       opposite_d;
	logic       full_d;
	logic [7:0] held_d;
	logic       fv_d;
	logic [7:0] fb_d;
	logic       fp_d;

	logic [7:0] phase_inc;
	logic [7:0] duty_ext;
	logic       tick_full;
	logic       tick_burst;

	// take an item when the result register is free or being drained
	assign op_pop = op_valid && (!rsp_valid || rsp_ready);

	// modulation counter step
	assign phase_inc  = (phase_q == dcbv_pkg::PHASE_LAST) ? 8'd0 : phase_q + 8'd1;
	assign duty_ext   = {1'b0, burst_duty_q};
	assign tick_full  = phase_inc < duty_ext;
	assign tick_burst = tick_full || ((phase_inc >= dcbv_pkg::HALF_PHASES) &&
		(phase_inc < duty_ext + dcbv_pkg::HALF_PHASES));

	// next state per operation
	always_comb begin
		proto_d      = proto_q;
		pending_d    = pending_q;
		freq_d       = freq_q;
		level_d      = level_q;
		burst_duty_d = burst_duty_q;
		drive_d      = drive_q;
		phase_d      = phase_q;
		opposite_d   = opposite_q;
		full_d       = full_q;
		held_d       = held_q;
		fv_d         = 1'b0;
		fb_d         = 8'd0;
		fp_d         = 1'b0;
		case (op.kind)
			dcbv_pkg::OP_TICK: begin
				if (drive_q) begin
					phase_d    = phase_inc;
					opposite_d = tick_burst;
					if (tick_full && !full_q) begin
						held_d = dcbv_pkg::period_lookup(freq_q);
						full_d = 1'b1;
					end else if (!tick_full && full_q) begin
						held_d = 8'd0;
						full_d = 1'b0;
					end
				end
			end
			dcbv_pkg::OP_FWD: begin
				proto_d = dcbv_pkg::PH_IDLE;
				fv_d    = 1'b1;
				fb_d    = op.data;
				fp_d    = op.parity;
			end
			dcbv_pkg::OP_START: begin
				proto_d = dcbv_pkg::PH_DUTY;
			end
			dcbv_pkg::OP_STOP: begin
				proto_d = dcbv_pkg::PH_IDLE;
				drive_d = 1'b0;
				level_d = 7'd0;
			end
			dcbv_pkg::OP_DATA: begin
				if (proto_q == dcbv_pkg::PH_DUTY) begin
					pending_d = (op.data[6:0] > dcbv_pkg::DUTY_MAX) ?
						dcbv_pkg::DUTY_MAX : op.data[6:0];
					proto_d   = dcbv_pkg::PH_FREQ;
				end else if (proto_q == dcbv_pkg::PH_FREQ) begin
					freq_d       = op.data[2:0];
					drive_d      = 1'b1;
					level_d      = pending_q;
					burst_duty_d = pending_q;
					proto_d      = dcbv_pkg::PH_IDLE;
				end else begin
					fv_d = 1'b1;
					fb_d = op.data;
					fp_d = op.parity;
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proto_q      <= dcbv_pkg::PH_IDLE;
			pending_q    <= 7'd0;
			freq_q       <= dcbv_pkg::FREQ_RESET;
			level_q      <= 7'd0;
			burst_duty_q <= 7'd0;
			drive_q      <= 1'b0;
			phase_q      <= 8'd0;
			opposite_q   <= 1'b0;
			full_q       <= 1'b0;
			held_q       <= 8'd0;
			rsp_valid    <= 1'b0;
		end else begin
			if (op_pop) begin
				proto_q      <= proto_d;
				pending_q    <= pending_d;
				freq_q       <= freq_d;
				level_q      <= level_d;
				burst_duty_q <= burst_duty_d;
				drive_q      <= drive_d;
				phase_q      <= phase_d;
				opposite_q   <= opposite_d;
				full_q       <= full_d;
				held_q       <= held_d;
				rsp_valid    <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid    <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (op_pop) begin
			rsp.fwd_valid        <= fv_d;
			rsp.fwd_byte         <= fb_d;
			rsp.fwd_parity       <= fp_d;
			rsp.drive_on         <= drive_d;
			rsp.period_value     <= dcbv_pkg::period_lookup(freq_d);
			rsp.compare_high     <= held_d;
			rsp.compare_low      <= full_d ? 7'd0 : dcbv_pkg::LOW_COMPARE;
			rsp.outputs_opposite <= opposite_d;
			rsp.duty_level       <= level_d;
		end
	end

endmodule

`default_nettype wire

@@ design/daisy_chain_burst_vibration_ctrl.sv @@
// top level of the daisy-chain burst vibration controller
//
//  channel  signals                   direction  item
//  req      req_valid req_ready req   in         serial word or timer tick
//  rsp      rsp_valid rsp_ready rsp   out        one result per item
//
// one item per cycle sustained while rsp_ready is high; the front decodes in the
// accept cycle, the queue registers it, then the back updates state and rsp valid
// the operation queue lets the front keep accepting while rsp is stalled
// req_ready drops only when the queue is full
// arst_n clears all protocol and modulation state, queue and result valid
`default_nettype none

module daisy_chain_burst_vibration_ctrl #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   req_valid,
	output logic                  req_ready,
	input  wire  dcbv_pkg::req_t  req,
	output logic                  rsp_valid,
	input  wire                   rsp_ready,
	output dcbv_pkg::rsp_t        rsp
);

	dcbv_pkg::op_t dec_op;
	dcbv_pkg::op_t head_op;
	logic          q_full;
	logic          q_not_empty;
	logic          q_pop;

	assign req_ready = !q_full;

	// decode
	dcbv_front u_front (
		.req (req),
		.op  (dec_op)
	);

	// operation queue
	dcbv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (req_valid && req_ready),
		.push_op   (dec_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_op   (head_op)
	);

	// execute
	dcbv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_not_empty),
		.op        (head_op),
		.op_pop    (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
